// ===== design/mlp_pkg.sv =====
// shared types and codes for the masonry lane placement unit
// no dependencies; used by the lane cells and the top level
package mlp_pkg;

    localparam int LANES_DEF = 16;
    localparam int POS_W     = 24;
    localparam int HEIGHT_W  = 20;
    localparam int GAP_W     = 16;
    localparam int THR_W     = 20;
    localparam int COUNT_W   = 5;
    localparam int LANE_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LANE_COUNT    = 2'd0,
        CFG_TIE_THRESHOLD = 2'd1,
        CFG_STACKING_GAP  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_LOAD,
        OP_SPREAD,
        OP_ROTATE,
        OP_WRITE,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   value;
    } t_cell_ctl;

endpackage

// ===== design/mlp_in_if.sv =====
// input channel of the placement unit: action, span and height
// depends on mlp_pkg for field widths
interface mlp_in_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [mlp_pkg::COUNT_W-1:0]    item_span;
    logic [mlp_pkg::HEIGHT_W-1:0]   item_height;

    modport source (output valid, output action, output item_span, output item_height,
                    input ready);
    modport sink   (input valid, input action, input item_span, input item_height,
                    output ready);
endinterface

// ===== design/mlp_out_if.sv =====
// result channel of the placement unit: lane, offset and content extent
// depends on mlp_pkg for field widths
interface mlp_out_if;
    logic                           valid;
    logic                           ready;
    logic [mlp_pkg::LANE_W-1:0]     chosen_lane;
    logic [mlp_pkg::POS_W-1:0]      top_offset;
    logic [mlp_pkg::POS_W-1:0]      content_extent;

    modport source (output valid, output chosen_lane, output top_offset,
                    output content_extent, input ready);
    modport sink   (input valid, input chosen_lane, input top_offset,
                    input content_extent, output ready);
endinterface

// ===== design/mlp_cell.sv =====
// one lane cell: running position plus a shift copy and a window maximum
// depends on mlp_pkg for the control struct and operation codes
module mlp_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mlp_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_sel,
    input  logic [mlp_pkg::POS_W-1:0]   i_t_next,
    input  logic [mlp_pkg::POS_W-1:0]   i_w_next,
    output logic [mlp_pkg::POS_W-1:0]   o_t,
    output logic [mlp_pkg::POS_W-1:0]   o_w
);

    logic [mlp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [mlp_pkg::POS_W-1:0] r_t, n_t;
    logic [mlp_pkg::POS_W-1:0] r_w, n_w;

    always_comb begin
        n_pos = r_pos;
        n_t   = r_t;
        n_w   = r_w;
        unique case (i_ctl.op)
            mlp_pkg::OP_CLEAR: begin
                n_pos = '0;
            end
            mlp_pkg::OP_LOAD: begin
                n_t = r_pos;
                n_w = r_pos;
            end
            mlp_pkg::OP_SPREAD: begin
                // neighbour's lane slides in, window maximum grows by one lane
                n_t = i_t_next;
                n_w = (i_t_next > r_w) ? i_t_next : r_w;
            end
            mlp_pkg::OP_ROTATE: begin
                n_w = i_w_next;
            end
            mlp_pkg::OP_WRITE: begin
                if (i_sel) begin
                    n_pos = i_ctl.value;
                end
                n_t = i_sel ? i_ctl.value : r_pos;
            end
            mlp_pkg::OP_SHIFT: begin
                n_t = i_t_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= n_t;
        r_w <= n_w;
    end

    assign o_t = r_t;
    assign o_w = r_w;

endmodule

// ===== design/masonry_lane_placement_unit.sv =====
// place: spread over the span, a full-ring minimum scan, a tie scan (up to the window picked,
// or all windows on fallback), the write, an extent scan over the lanes in use, then done;
// clear goes straight to done. one transaction at a time; a finished result waits in the output
// register while the next transaction is taken
// synchronous active-low reset zeroes every lane, the cursor and the registers
// (lane count 1), and empties the output register
module masonry_lane_placement_unit #(
    parameter int LANES = mlp_pkg::LANES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mlp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mlp_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    mlp_in_if.sink                          i_in,
    mlp_out_if.source                       o_out
);

    localparam int CW = $clog2(LANES + 1);
    localparam int POS_W = mlp_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SPREAD, S_MIN, S_TIE, S_WRITE, S_EXTENT, S_DONE
    } t_state;

    t_state r_state;

    logic [mlp_pkg::COUNT_W-1:0]  r_lane_count;
    logic [mlp_pkg::THR_W-1:0]    r_thr;
    logic [mlp_pkg::GAP_W-1:0]    r_gap;

    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                r_span;
    logic [CW-1:0]                r_win;
    logic [CW-1:0]                r_n;
    logic [CW-1:0]                r_lane;
    logic [CW-1:0]                r_first;
    logic                         r_found;
    logic [POS_W-1:0]             r_min;
    logic [POS_W-1:0]             r_top;
    logic [POS_W-1:0]             r_first_top;
    logic [POS_W-1:0]             r_ext;
    logic [mlp_pkg::HEIGHT_W-1:0] r_height;
    logic [mlp_pkg::COUNT_W-1:0]  r_cursor;

    logic [mlp_pkg::LANE_W-1:0]   r_res_lane;
    logic [POS_W-1:0]             r_res_off;
    logic [POS_W-1:0]             r_res_ext;

    logic                         r_o_valid;
    logic [mlp_pkg::LANE_W-1:0]   r_o_lane;
    logic [POS_W-1:0]             r_o_off;
    logic [POS_W-1:0]             r_o_ext;

    // cell chain
    logic [POS_W-1:0]  t_arr [LANES];
    logic [POS_W-1:0]  w_arr [LANES];
    logic [LANES-1:0]  sel;
    mlp_pkg::t_cell_ctl ctl;

    // combinational helpers
    logic [CW-1:0]     n_use, span_c, win_c;
    logic [POS_W-1:0]  head_w, head_t;
    logic [POS_W:0]    limit;
    logic              cand;
    logic [CW-1:0]     first_idx;
    logic [POS_W-1:0]  first_val;
    logic [POS_W+1:0]  sum;
    logic [POS_W-1:0]  next_pos;
    logic [POS_W-1:0]  ext_max, ext_out;
    logic              in_acc;

    assign head_w = w_arr[0];
    assign head_t = t_arr[0];
    assign in_acc = i_in.valid && i_in.ready;

    always_comb begin
        if (r_lane_count == '0) begin
            n_use = CW'(1);
        end else if (int'(r_lane_count) > LANES) begin
            n_use = CW'(LANES);
        end else begin
            n_use = CW'(r_lane_count);
        end
        if (i_in.item_span == '0) begin
            span_c = CW'(1);
        end else if (int'(i_in.item_span) > int'(n_use)) begin
            span_c = n_use;
        end else begin
            span_c = CW'(i_in.item_span);
        end
        win_c = n_use - span_c + CW'(1);
    end

    always_comb begin
        limit = {1'b0, r_min} + (POS_W + 1)'(r_thr);
        cand  = {1'b0, head_w} <= limit;
        if (cand && !r_found) begin
            first_idx = r_cnt;
            first_val = head_w;
        end else begin
            first_idx = r_first;
            first_val = r_first_top;
        end
        sum = (POS_W + 2)'(r_top) + (POS_W + 2)'(r_height) + (POS_W + 2)'(r_gap);
        next_pos = (sum[POS_W+1:POS_W] != 2'b00) ? {POS_W{1'b1}} : sum[POS_W-1:0];
        ext_max = (head_t > r_ext) ? head_t : r_ext;
        ext_out = (ext_max > POS_W'(r_gap)) ? ext_max - POS_W'(r_gap) : '0;
    end

    // window of the chosen lane, for the write pass
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            sel[k] = (k >= int'(r_lane)) && (k < int'(r_lane) + int'(r_span));
        end
    end

    always_comb begin
        ctl.value = next_pos;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    ctl.op = i_in.action ? mlp_pkg::OP_CLEAR : mlp_pkg::OP_LOAD;
                end else begin
                    ctl.op = mlp_pkg::OP_HOLD;
                end
            end
            S_SPREAD: ctl.op = mlp_pkg::OP_SPREAD;
            S_MIN:    ctl.op = mlp_pkg::OP_ROTATE;
            S_TIE:    ctl.op = mlp_pkg::OP_ROTATE;
            S_WRITE:  ctl.op = mlp_pkg::OP_WRITE;
            S_EXTENT: ctl.op = mlp_pkg::OP_SHIFT;
            default:  ctl.op = mlp_pkg::OP_HOLD;
        endcase
    end

    for (genvar k = 0; k < LANES; k++) begin : g_cell
        logic [POS_W-1:0] t_next;
        if (k == LANES - 1) begin : g_last
            assign t_next = '0;
        end else begin : g_mid
            assign t_next = t_arr[k+1];
        end
        mlp_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_sel    (sel[k]),
            .i_t_next (t_next),
            .i_w_next (w_arr[(k + 1) % LANES]),
            .o_t      (t_arr[k]),
            .o_w      (w_arr[k])
        );
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_count <= mlp_pkg::COUNT_W'(1);
            r_thr        <= '0;
            r_gap        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mlp_pkg::CFG_LANE_COUNT:    r_lane_count <= i_cfg_data[mlp_pkg::COUNT_W-1:0];
                mlp_pkg::CFG_TIE_THRESHOLD: r_thr        <= i_cfg_data[mlp_pkg::THR_W-1:0];
                mlp_pkg::CFG_STACKING_GAP:  r_gap        <= i_cfg_data[mlp_pkg::GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cursor  <= '0;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            r_found   <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_o_valid || o_out.ready)) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.action) begin
                            r_cursor   <= '0;
                            r_res_lane <= '0;
                            r_res_off  <= '0;
                            r_res_ext  <= '0;
                            r_state    <= S_DONE;
                        end else begin
                            r_height <= i_in.item_height;
                            r_span   <= span_c;
                            r_win    <= win_c;
                            r_n      <= n_use;
                            r_found  <= 1'b0;
                            if (span_c == CW'(1)) begin
                                r_cnt   <= '0;
                                r_state <= S_MIN;
                            end else begin
                                r_cnt   <= CW'(1);
                                r_state <= S_SPREAD;
                            end
                        end
                    end
                end
                S_SPREAD: begin
                    if (r_cnt == r_span - CW'(1)) begin
                        r_cnt   <= '0;
                        r_state <= S_MIN;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_MIN: begin
                    // full turn of the ring so the windows come back in order
                    if (r_cnt < r_win) begin
                        if (r_cnt == '0 || head_w < r_min) begin
                            r_min <= head_w;
                        end
                    end
                    if (r_cnt == CW'(LANES - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_TIE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_TIE: begin
                    r_first     <= first_idx;
                    r_first_top <= first_val;
                    if (cand) begin
                        r_found <= 1'b1;
                    end
                    if (cand && int'(r_cnt) >= int'(r_cursor)) begin
                        r_lane  <= r_cnt;
                        r_top   <= head_w;
                        r_state <= S_WRITE;
                    end else if (r_cnt == r_win - CW'(1)) begin
                        // wrap to the first candidate
                        r_lane  <= first_idx;
                        r_top   <= first_val;
                        r_state <= S_WRITE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_WRITE: begin
                    r_cursor   <= mlp_pkg::COUNT_W'(r_lane + r_span);
                    r_res_lane <= mlp_pkg::LANE_W'(r_lane);
                    r_res_off  <= r_top;
                    r_ext      <= '0;
                    r_cnt      <= '0;
                    r_state    <= S_EXTENT;
                end
                S_EXTENT: begin
                    r_ext <= ext_max;
                    if (r_cnt == r_n - CW'(1)) begin
                        r_res_ext <= ext_out;
                        r_state   <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_lane  <= r_res_lane;
                        r_o_off   <= r_res_off;
                        r_o_ext   <= r_res_ext;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_o_valid;
    assign o_out.chosen_lane     = r_o_lane;
    assign o_out.top_offset      = r_o_off;
    assign o_out.content_extent  = r_o_ext;

endmodule
